// File: sv/refcounted_segment_allocator_unit_defines.svh
// Assertion macros used by the segment allocator top level.
// Depends on nothing; included by the top level.
`ifndef REFCOUNTED_SEGMENT_ALLOCATOR_UNIT_DEFINES_SVH
`define REFCOUNTED_SEGMENT_ALLOCATOR_UNIT_DEFINES_SVH

// same-cycle implication
`define RSA_ASSERT_IMPL(lbl, ck, rn, a, c) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (a) |-> (c)) \
		else $error("segment allocator check failed");

// next-cycle implication
`define RSA_ASSERT_NEXT(lbl, ck, rn, a, c) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (a) |=> (c)) \
		else $error("segment allocator check failed");

`endif

// File: sv/rsa_pkg.sv
// Types, constants and helpers of the segment allocator.
// No dependencies; used by every file but the defines header.
package rsa_pkg;
	localparam int MAX_SEGMENTS = 16;
	localparam int PAGE_BYTES   = 4096;
	localparam int PAGE_SHIFT   = $clog2(PAGE_BYTES);
	localparam int SLOT_W       = $clog2(MAX_SEGMENTS);
	localparam int OFF_W        = 28;

	localparam logic [1:0] KIND_ALLOC  = 2'd0;
	localparam logic [1:0] KIND_ATTACH = 2'd1;
	localparam logic [1:0] KIND_DETACH = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NO_SPACE  = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [1:0] ST_FULL      = 2'd3;

	typedef logic [SLOT_W-1:0] slot_t;

	typedef struct packed {
		logic [15:0] id;
		logic [15:0] base;
		logic [16:0] count;
		logic [15:0] refs;
	} entry_t;

	// write request into the segment table
	typedef struct packed {
		logic   en;
		slot_t  addr;
		logic   set_valid;
		entry_t data;
	} tbl_wr_t;

	// byte offset of a page, low 28 bits
	function automatic logic [OFF_W-1:0] page_offset(input logic [15:0] page);
		page_offset = OFF_W'(page) << PAGE_SHIFT;
	endfunction
endpackage

// File: sv/rsa_if.sv
// Channel interfaces of the segment allocator: request, result, configuration.
// Depends on rsa_pkg.
interface rsa_req_if import rsa_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [1:0]        kind;
	logic [31:0]       request_bytes;
	logic [15:0]       segment_number;
	logic [OFF_W-1:0]  segment_offset;
	modport source (output valid, kind, request_bytes, segment_number, segment_offset,
		input ready);
	modport sink (input valid, kind, request_bytes, segment_number, segment_offset,
		output ready);
endinterface

interface rsa_rsp_if import rsa_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [1:0]        status;
	logic [15:0]       given_id;
	logic [OFF_W-1:0]  start_offset;
	modport source (output valid, status, given_id, start_offset, input ready);
	modport sink (input valid, status, given_id, start_offset, output ready);
endinterface

interface rsa_cfg_if ();
	logic        valid;
	logic        ready;
	logic [15:0] region_pages;
	modport source (output valid, region_pages, input ready);
	modport sink (input valid, region_pages, output ready);
endinterface

// File: sv/refcounted_segment_allocator_unit.sv
// Reference-counted first-fit segment allocator, top level.
// Depends on rsa_pkg, the channel interfaces, rsa_table, rsa_ctrl and the defines header.
//
// One item is handled at a time. The result waits in an output register so the
// next item can be taken meanwhile. An attach, a detach, or an allocate that finds
// the table full sweeps the 16-entry table RAM once, one read a cycle. It then
// decides and writes back, and the done state loads the result once the output
// register is free. After the decision an allocate tests the region start. If
// that fails it tests the end of each live segment in turn. Each test is another
// sweep of the table, and a live entry for a candidate is first fetched through
// the candidate request and get states. A free slot is skipped in the candidate
// request state. The new entry is written back in the commit state. A request
// that is zero sized or too big, or an unknown kind, goes straight to the done
// state without a sweep. The table is empty right after reset, with no clearing
// pass.
`include "refcounted_segment_allocator_unit_defines.svh"

module refcounted_segment_allocator_unit import rsa_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	rsa_req_if.sink    req,
	rsa_rsp_if.source  rsp,
	rsa_cfg_if.sink    cfg
);
	slot_t                   rd_addr;
	entry_t                  rd_data;
	tbl_wr_t                 wr;
	logic [MAX_SEGMENTS-1:0] valid;

	rsa_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr      (wr),
		.valid   (valid)
	);

	rsa_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rsp     (rsp),
		.cfg     (cfg),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr      (wr),
		.valid   (valid)
	);

	// table writes only while an item is in progress
	`RSA_ASSERT_IMPL(a_wr_busy, clk, arst_n, wr.en, !req.ready)
	// never two write-backs back to back
	`RSA_ASSERT_NEXT(a_wr_once, clk, arst_n, wr.en, !wr.en)
	// an accepted item makes the block busy
	`RSA_ASSERT_NEXT(a_acc_busy, clk, arst_n, req.valid && req.ready, !req.ready)
endmodule

// File: sv/rsa_table.sv
// Segment table: entry RAM with registered read, plus valid flops.
// Depends on rsa_pkg.
module rsa_table import rsa_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  slot_t                   rd_addr,
	output entry_t                  rd_data,
	input  tbl_wr_t                 wr,
	output logic [MAX_SEGMENTS-1:0] valid
);
	entry_t                  mem [MAX_SEGMENTS];
	logic [MAX_SEGMENTS-1:0] valid_q;

	// entry RAM, read data registered
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		rd_data <= mem[rd_addr];
	end

	// valid bits, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr.en) begin
			valid_q[wr.addr] <= wr.set_valid;
		end
	end

	assign valid = valid_q;
endmodule

// File: sv/rsa_ctrl.sv
// Request sequencer: sweeps the table, decides, writes back, holds the result.
// Depends on rsa_pkg and the channel interfaces.
module rsa_ctrl import rsa_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	rsa_req_if.sink                 req,
	rsa_rsp_if.source               rsp,
	rsa_cfg_if.sink                 cfg,
	output slot_t                   rd_addr,
	input  entry_t                  rd_data,
	output tbl_wr_t                 wr,
	input  logic [MAX_SEGMENTS-1:0] valid
);
	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_SCAN   = 8'b0000_0010,
		S_DECIDE = 8'b0000_0100,
		S_CREQ   = 8'b0000_1000,
		S_CGET   = 8'b0001_0000,
		S_FIT    = 8'b0010_0000,
		S_COMMIT = 8'b0100_0000,
		S_DONE   = 8'b1000_0000
	} state_t;

	localparam int CNT_W = SLOT_W + 1;
	localparam logic [CNT_W-1:0] CNT_END = CNT_W'(MAX_SEGMENTS);

	state_t            state_q;
	logic [15:0]       region_q;
	logic [1:0]        kind_q;
	logic [16:0]       pages_q;
	logic [15:0]       num_q;
	logic [OFF_W-1:0]  off_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              sv_s1;
	slot_t             sidx_s1;
	logic              any_q;
	logic [15:0]       max_q;
	logic              hit_q;
	slot_t             hit_slot_q;
	entry_t            hit_ent_q;
	slot_t             free_q;
	logic [CNT_W-1:0]  k_q;
	logic              best_q;
	logic [15:0]       best_id_q;
	logic [15:0]       best_base_q;
	logic [17:0]       cand_q;
	logic [15:0]       cid_q;
	logic              fit_q;
	logic [1:0]        res_status_q;
	logic [15:0]       res_id_q;
	logic [OFF_W-1:0]  res_off_q;
	logic              out_valid_q;
	logic [1:0]        out_status_q;
	logic [15:0]       out_id_q;
	logic [OFF_W-1:0]  out_off_q;

	logic              accept;
	logic [32:0]       pages_in;
	logic              free_any;
	slot_t             free_slot;
	logic [CNT_W-1:0]  k_m1;
	logic              sweep_last;
	logic              match;
	logic [17:0]       seg_end;
	logic [18:0]       cand_top;
	logic              fit_next;
	logic [17:0]       cget_end;
	logic [15:0]       refs_dec;

	// configuration register, always ready
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_q <= '0;
		end else if (cfg.valid) begin
			region_q <= cfg.region_pages;
		end
	end

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;

	// byte size rounded up to pages
	assign pages_in = 33'(req.request_bytes >> PAGE_SHIFT)
		+ 33'(|(req.request_bytes & 32'(PAGE_BYTES - 1)));

	// lowest free slot
	always_comb begin
		free_any  = 1'b0;
		free_slot = '0;
		for (int i = MAX_SEGMENTS - 1; i >= 0; i--) begin
			if (!valid[i]) begin
				free_any  = 1'b1;
				free_slot = SLOT_W'(i);
			end
		end
	end

	// table read address: sweep counter, or one candidate entry
	assign k_m1    = k_q - 1'b1;
	assign rd_addr = (state_q == S_CREQ) ? k_m1[SLOT_W-1:0] : cnt_q[SLOT_W-1:0];

	assign sweep_last = sv_s1 && (sidx_s1 == SLOT_W'(MAX_SEGMENTS - 1));

	// lookup match during the scan sweep
	assign match = valid[sidx_s1] && ((kind_q == KIND_ATTACH) ? (rd_data.id == num_q)
		: (page_offset(rd_data.base) == off_q));

	// overlap of the current candidate with the swept entry
	assign seg_end  = 18'(rd_data.base) + 18'(rd_data.count);
	assign cand_top = 19'(cand_q) + 19'(pages_q);
	assign fit_next = fit_q && !(sv_s1 && valid[sidx_s1]
		&& (cand_top > 19'(rd_data.base)) && (19'(cand_q) < 19'(seg_end)));
	assign cget_end = 18'(rd_data.base) + 18'(rd_data.count);

	assign refs_dec = (hit_ent_q.refs == 16'd0) ? 16'd0 : hit_ent_q.refs - 16'd1;

	// table write-back
	always_comb begin
		wr = '0;
		unique case (state_q)
			S_DECIDE: begin
				if (hit_q && kind_q == KIND_ATTACH) begin
					wr.en        = 1'b1;
					wr.addr      = hit_slot_q;
					wr.set_valid = 1'b1;
					wr.data      = hit_ent_q;
					if (hit_ent_q.refs != 16'hFFFF) begin
						wr.data.refs = hit_ent_q.refs + 16'd1;
					end
				end else if (hit_q && kind_q == KIND_DETACH) begin
					wr.en   = 1'b1;
					wr.addr = hit_slot_q;
					if (refs_dec != 16'd0) begin
						wr.set_valid = 1'b1;
						wr.data      = hit_ent_q;
						wr.data.refs = refs_dec;
					end
				end
			end
			S_COMMIT: begin
				wr.en         = 1'b1;
				wr.addr       = free_q;
				wr.set_valid  = 1'b1;
				wr.data.id    = any_q ? max_q + 16'd1 : 16'd0;
				wr.data.base  = best_base_q;
				wr.data.count = pages_q;
				wr.data.refs  = 16'd0;
			end
			S_IDLE, S_SCAN, S_CREQ, S_CGET, S_FIT, S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sv_s1   <= 1'b0;
			cnt_q   <= '0;
			k_q     <= '0;
			best_q  <= 1'b0;
			any_q   <= 1'b0;
			hit_q   <= 1'b0;
			fit_q   <= 1'b0;
		end else begin
			// sweep pipeline: issue one read a cycle, look at it the next
			sv_s1 <= 1'b0;
			if ((state_q == S_SCAN || state_q == S_FIT) && cnt_q != CNT_END) begin
				sv_s1   <= 1'b1;
				sidx_s1 <= cnt_q[SLOT_W-1:0];
				cnt_q   <= cnt_q + 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						kind_q       <= req.kind;
						pages_q      <= pages_in[16:0];
						num_q        <= req.segment_number;
						off_q        <= req.segment_offset;
						any_q        <= 1'b0;
						max_q        <= '0;
						hit_q        <= 1'b0;
						best_q       <= 1'b0;
						cnt_q        <= '0;
						res_status_q <= ST_OK;
						res_id_q     <= '0;
						res_off_q    <= '0;
						if (req.kind == KIND_ALLOC && (pages_in == 33'd0
								|| pages_in > 33'(region_q))) begin
							res_status_q <= ST_NO_SPACE;
							state_q      <= S_DONE;
						end else if (req.kind != KIND_ALLOC && req.kind != KIND_ATTACH
								&& req.kind != KIND_DETACH) begin
							res_status_q <= ST_NOT_FOUND;
							state_q      <= S_DONE;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (sv_s1 && valid[sidx_s1]) begin
						any_q <= 1'b1;
						if (!any_q || rd_data.id > max_q) begin
							max_q <= rd_data.id;
						end
						if (match && (!hit_q || rd_data.id < hit_ent_q.id)) begin
							hit_q      <= 1'b1;
							hit_slot_q <= sidx_s1;
							hit_ent_q  <= rd_data;
						end
					end
					if (sweep_last) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					state_q <= S_DONE;
					if (kind_q == KIND_ALLOC) begin
						if (!free_any || (any_q && max_q == 16'hFFFF)) begin
							res_status_q <= ST_FULL;
						end else begin
							free_q  <= free_slot;
							k_q     <= '0;
							cand_q  <= '0;
							fit_q   <= 1'b1;
							cnt_q   <= '0;
							state_q <= S_FIT;
						end
					end else if (!hit_q) begin
						res_status_q <= ST_NOT_FOUND;
					end else if (kind_q == KIND_ATTACH) begin
						res_off_q <= page_offset(hit_ent_q.base);
					end
				end
				S_CREQ: begin
					if (valid[k_m1[SLOT_W-1:0]]) begin
						state_q <= S_CGET;
					end else if (k_q == CNT_END) begin
						if (best_q) begin
							state_q <= S_COMMIT;
						end else begin
							res_status_q <= ST_NO_SPACE;
							state_q      <= S_DONE;
						end
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				S_CGET: begin
					if (best_q && rd_data.id > best_id_q) begin
						if (k_q == CNT_END) begin
							state_q <= S_COMMIT;
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= S_CREQ;
						end
					end else begin
						cand_q  <= cget_end;
						cid_q   <= rd_data.id;
						fit_q   <= (19'(cget_end) + 19'(pages_q)) <= 19'(region_q);
						cnt_q   <= '0;
						state_q <= S_FIT;
					end
				end
				S_FIT: begin
					fit_q <= fit_next;
					if (sweep_last) begin
						if (k_q == '0) begin
							if (fit_next) begin
								best_base_q <= '0;
								state_q     <= S_COMMIT;
							end else begin
								k_q     <= CNT_W'(1);
								state_q <= S_CREQ;
							end
						end else begin
							if (fit_next) begin
								best_q      <= 1'b1;
								best_id_q   <= cid_q;
								best_base_q <= cand_q[15:0];
							end
							if (k_q != CNT_END) begin
								k_q     <= k_q + 1'b1;
								state_q <= S_CREQ;
							end else if (best_q || fit_next) begin
								state_q <= S_COMMIT;
							end else begin
								res_status_q <= ST_NO_SPACE;
								state_q      <= S_DONE;
							end
						end
					end
				end
				S_COMMIT: begin
					res_status_q <= ST_OK;
					res_id_q     <= any_q ? max_q + 16'd1 : 16'd0;
					res_off_q    <= page_offset(best_base_q);
					state_q      <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || rsp.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && (!out_valid_q || rsp.ready)) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && (!out_valid_q || rsp.ready)) begin
			out_status_q <= res_status_q;
			out_id_q     <= res_id_q;
			out_off_q    <= res_off_q;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.status       = out_status_q;
	assign rsp.given_id     = out_id_q;
	assign rsp.start_offset = out_off_q;
endmodule

// File: dv/rsa_tb_scoreboard.sv
// Scoreboard class for the segment allocator testbench: predicts the table and checks results.
// Depends on rsa_pkg.
package rsa_tb_scoreboard_pkg;
	import rsa_pkg::*;

	typedef struct packed {
		logic [1:0]       kind;
		logic [31:0]      request_bytes;
		logic [15:0]      segment_number;
		logic [OFF_W-1:0] segment_offset;
	} seg_req_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [15:0]      given_id;
		logic [OFF_W-1:0] start_offset;
	} seg_rsp_t;

	class segment_table_sb;
		logic [15:0] region_pages;
		bit          live [MAX_SEGMENTS];
		logic [15:0] seg_id [MAX_SEGMENTS];
		logic [15:0] seg_base [MAX_SEGMENTS];
		logic [16:0] seg_pages [MAX_SEGMENTS];
		logic [15:0] seg_refs [MAX_SEGMENTS];
		seg_rsp_t    pending_rsp [$];
		int          mismatches;

		function new();
			region_pages = '0;
			mismatches = 0;
			for (int i = 0; i < MAX_SEGMENTS; i++) begin
				live[i] = 0; seg_id[i] = '0; seg_base[i] = '0;
				seg_pages[i] = '0; seg_refs[i] = '0;
			end
		endfunction

		function logic [OFF_W-1:0] to_bytes(logic [15:0] page);
			longint unsigned b;
			b = longint'(page) * PAGE_BYTES;
			return b[OFF_W-1:0];
		endfunction

		// does [base, base+pages) lie in the region and clear of all live segments
		function bit fits(longint unsigned base, longint unsigned pages);
			longint unsigned b, e;
			if (base + pages > region_pages) return 0;
			for (int i = 0; i < MAX_SEGMENTS; i++) begin
				if (!live[i]) continue;
				b = seg_base[i];
				e = b + seg_pages[i];
				if (base + pages > b && base < e) return 0;
			end
			return 1;
		endfunction

		function seg_rsp_t allocate(logic [31:0] bytes);
			seg_rsp_t r;
			longint unsigned pages, base, c;
			int free_slot, best;
			bit any, found;
			logic [15:0] max_id;
			r = '0; free_slot = -1; best = -1; any = 0; found = 0; max_id = '0; base = 0;
			pages = (longint'(bytes) + PAGE_BYTES - 1) / PAGE_BYTES;
			if (pages == 0 || pages > region_pages) begin
				r.status = ST_NO_SPACE;
				return r;
			end
			for (int i = 0; i < MAX_SEGMENTS; i++) begin
				if (live[i]) begin
					if (!any || seg_id[i] > max_id) max_id = seg_id[i];
					any = 1;
				end else if (free_slot < 0) begin
					free_slot = i;
				end
			end
			if (free_slot < 0 || (any && max_id == 16'hFFFF)) begin
				r.status = ST_FULL;
				return r;
			end
			if (fits(0, pages)) begin
				found = 1;
			end else begin
				// segment ends in ascending id order, first that fits wins
				for (int i = 0; i < MAX_SEGMENTS; i++) begin
					if (!live[i]) continue;
					if (best >= 0 && seg_id[i] > seg_id[best]) continue;
					c = longint'(seg_base[i]) + seg_pages[i];
					if (fits(c, pages)) begin
						best = i;
						base = c;
					end
				end
				found = best >= 0;
			end
			if (!found) begin
				r.status = ST_NO_SPACE;
				return r;
			end
			live[free_slot] = 1;
			seg_id[free_slot] = any ? max_id + 16'd1 : 16'd0;
			seg_base[free_slot] = base[15:0];
			seg_pages[free_slot] = pages[16:0];
			seg_refs[free_slot] = '0;
			r.status = ST_OK;
			r.given_id = seg_id[free_slot];
			r.start_offset = to_bytes(base[15:0]);
			return r;
		endfunction

		// note an accepted request and queue its expected result
		function void note_request(seg_req_t q);
			seg_rsp_t r;
			int hit;
			r = '0; hit = -1;
			case (q.kind)
				KIND_ALLOC: begin
					r = allocate(q.request_bytes);
				end
				KIND_ATTACH: begin
					r.status = ST_NOT_FOUND;
					for (int i = 0; i < MAX_SEGMENTS; i++) begin
						if (live[i] && seg_id[i] == q.segment_number) begin
							if (seg_refs[i] != 16'hFFFF) seg_refs[i]++;
							r.status = ST_OK;
							r.start_offset = to_bytes(seg_base[i]);
							break;
						end
					end
				end
				KIND_DETACH: begin
					for (int i = 0; i < MAX_SEGMENTS; i++) begin
						if (!live[i] || to_bytes(seg_base[i]) != q.segment_offset) continue;
						if (hit < 0 || seg_id[i] < seg_id[hit]) hit = i;
					end
					if (hit < 0) begin
						r.status = ST_NOT_FOUND;
					end else begin
						if (seg_refs[hit] != 0) seg_refs[hit]--;
						if (seg_refs[hit] == 0) begin
							live[hit] = 0; seg_id[hit] = '0;
							seg_base[hit] = '0; seg_pages[hit] = '0;
						end
						r.status = ST_OK;
					end
				end
				default: begin
					r.status = ST_NOT_FOUND;
				end
			endcase
			pending_rsp.push_back(r);
		endfunction

		function void check_result(seg_rsp_t got);
			seg_rsp_t exp;
			if (pending_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: status %0d id %0d offset 0x%07h",
						got.status, got.given_id, got.start_offset);
				return;
			end
			exp = pending_rsp.pop_front();
			if (got !== exp) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result mismatch: exp st %0d id %0d off 0x%07h, got st %0d id %0d off 0x%07h",
						exp.status, exp.given_id, exp.start_offset,
						got.status, got.given_id, got.start_offset);
			end
		endfunction
	endclass
endpackage

// File: dv/refcounted_segment_allocator_unit_tb.sv
// Top-level testbench of the segment allocator: drives requests and configuration, checks results.
// Depends on rsa_pkg, the channel interfaces, rsa_tb_scoreboard_pkg and the RTL.
module refcounted_segment_allocator_unit_tb import rsa_pkg::*, rsa_tb_scoreboard_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 3000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	longint unsigned cycles = 0;
	bit stim_done = 0;

	rsa_req_if req ();
	rsa_rsp_if rsp ();
	rsa_cfg_if cfg ();

	refcounted_segment_allocator_unit i_dut (
		.clk(clk), .arst_n(arst_n), .req(req.sink), .rsp(rsp.source), .cfg(cfg.sink)
	);

	segment_table_sb table_sb = new();

	always #10 clk = ~clk;

	initial begin
		req.valid = 1'b0; req.kind = '0; req.request_bytes = '0;
		req.segment_number = '0; req.segment_offset = '0;
		rsp.ready = 1'b0;
		cfg.valid = 1'b0; cfg.region_pages = '0;
	end

	// timeout watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// result side: random stall, then accept and check
	bit rsp_no_stall = 0;
	initial begin
		int w;
		wait (arst_n);
		forever begin
			w = rsp_no_stall ? 0 : $urandom_range(0, 12);
			if (w != 0) begin
				rsp.ready <= 1'b0;
				repeat (w) @(posedge clk);
			end
			rsp.ready <= 1'b1;
			@(posedge clk);
			while (!rsp.valid) @(posedge clk);
			table_sb.check_result({rsp.status, rsp.given_id, rsp.start_offset});
		end
	end

	bit req_no_gap = 0;

	// valid stays high after an accepted item until the next gap or release_request
	task automatic send_request(logic [1:0] kind, logic [31:0] bytes,
			logic [15:0] num, logic [OFF_W-1:0] off);
		int w;
		w = req_no_gap ? 0 : $urandom_range(0, 12);
		if (w != 0) begin
			req.valid <= 1'b0;
			repeat (w) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.kind <= kind;
		req.request_bytes <= bytes;
		req.segment_number <= num;
		req.segment_offset <= off;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		table_sb.note_request({kind, bytes, num, off});
	endtask

	task automatic release_request();
		req.valid <= 1'b0;
	endtask

	// region writes only when idle
	task automatic write_region(logic [15:0] pages);
		release_request();
		while (table_sb.pending_rsp.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		cfg.valid <= 1'b1;
		cfg.region_pages <= pages;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		table_sb.region_pages = pages;
		cfg.valid <= 1'b0;
	endtask

	// a random request; attaches and detaches are mostly aimed at live segments
	task automatic random_request(logic [15:0] pages_hint);
		int sel, s;
		logic [31:0] bytes;
		logic [15:0] num;
		logic [OFF_W-1:0] off;
		sel = $urandom_range(0, 99);
		s = $urandom_range(0, MAX_SEGMENTS - 1);
		num = 16'($urandom);
		off = OFF_W'($urandom);
		bytes = $urandom;
		if (sel < 40) begin
			case ($urandom_range(0, 5))
				0: bytes = $urandom;
				1: bytes = $urandom_range(0, 2);
				default: bytes = $urandom_range(1, (pages_hint / 4 + 1) * PAGE_BYTES);
			endcase
			send_request(KIND_ALLOC, bytes, num, off);
		end else if (sel < 65) begin
			if ($urandom_range(0, 3) != 0 && table_sb.live[s]) num = table_sb.seg_id[s];
			else if ($urandom_range(0, 1)) num = 16'($urandom_range(0, 20));
			send_request(KIND_ATTACH, bytes, num, off);
		end else if (sel < 95) begin
			if ($urandom_range(0, 3) != 0 && table_sb.live[s])
				off = table_sb.to_bytes(table_sb.seg_base[s]);
			send_request(KIND_DETACH, bytes, num, off);
		end else begin
			send_request(2'd3, bytes, num, off);
		end
	endtask

	initial begin
		logic [15:0] regions [6];
		regions = '{16'd64, 16'd0, 16'd8, 16'd65535, 16'd300, 16'd1};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table, zero region
		send_request(KIND_ALLOC, 32'd4096, 16'd0, '0);
		send_request(KIND_ATTACH, '0, 16'hFFFF, '0);
		send_request(KIND_DETACH, '0, '0, {OFF_W{1'b1}});
		send_request(2'd3, 32'hFFFF_FFFF, 16'hFFFF, {OFF_W{1'b1}});
		write_region(16'd20);
		send_request(KIND_ALLOC, 32'd0, '0, '0);
		send_request(KIND_ALLOC, 32'hFFFF_FFFF, '0, '0);
		send_request(KIND_ALLOC, 32'd1, '0, '0);
		send_request(KIND_ALLOC, 32'd4097, '0, '0);
		send_request(KIND_ALLOC, 32'd8192, '0, '0);
		send_request(KIND_ATTACH, '0, 16'd1, '0);
		send_request(KIND_ATTACH, '0, 16'd1, '0);
		send_request(KIND_DETACH, '0, '0, 28'h1000);
		send_request(KIND_DETACH, '0, '0, 28'h0);  // refs zero: freed at once
		send_request(KIND_ALLOC, 32'd4096, '0, '0);  // reuses the region start
		// fill the table to reach table full
		for (int i = 0; i < 14; i++) send_request(KIND_ALLOC, 32'd1, '0, '0);
		// shrink leaves live segments alone
		write_region(16'd2);
		send_request(KIND_ATTACH, '0, 16'd4, '0);
		for (int i = 0; i < 16; i++) send_request(KIND_DETACH, '0, '0, 28'(i * PAGE_BYTES));

		// random phases over several region sizes
		for (int ph = 0; ph < 6; ph++) begin
			write_region(regions[ph]);
			req_no_gap = (ph == 2);
			rsp_no_stall = (ph == 2);
			for (int n = 0; n < 180; n++) random_request(regions[ph]);
			req_no_gap = 0;
			rsp_no_stall = 0;
		end

		// back-to-back attaches on a fresh segment
		write_region(16'd4);
		while (table_sb.live[0] || table_sb.live[1] || table_sb.live[2]) begin
			for (int i = 0; i < MAX_SEGMENTS; i++)
				if (table_sb.live[i]) begin
					send_request(KIND_DETACH, '0, '0, table_sb.to_bytes(table_sb.seg_base[i]));
					break;
				end
		end
		send_request(KIND_ALLOC, 32'd100, '0, '0);
		req_no_gap = 1;
		rsp_no_stall = 1;
		for (int i = 0; i < 8; i++)
			send_request(KIND_ATTACH, '0, table_sb.seg_id[0], '0);
		req_no_gap = 0;
		rsp_no_stall = 0;

		release_request();
		while (table_sb.pending_rsp.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
		if (table_sb.mismatches == 0 && table_sb.pending_rsp.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule

// File: filelist.f
+incdir+sv
sv/rsa_pkg.sv
sv/rsa_if.sv
sv/rsa_table.sv
sv/rsa_ctrl.sv
sv/refcounted_segment_allocator_unit.sv
dv/rsa_tb_scoreboard.sv
dv/refcounted_segment_allocator_unit_tb.sv
